// File: design/rfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_pkg
// Shared constants, codes and controller/datapath types for the rotating
// 4bpp frame store.
// ----------------------------------------------------------------------------
package rfs_pkg;

    localparam int PANEL_WIDTH_DEF  = 256;
    localparam int PANEL_HEIGHT_DEF = 64;

    localparam int IDX_W       = 13;
    localparam int STORE_DEPTH = 8192;
    localparam int DATA_W      = 8;
    localparam int MODE_W      = 2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [MODE_W-1:0] ROT_0   = 2'd0;
    localparam logic [MODE_W-1:0] ROT_90  = 2'd1;
    localparam logic [MODE_W-1:0] ROT_180 = 2'd2;
    localparam logic [MODE_W-1:0] ROT_270 = 2'd3;

    typedef struct packed {
        logic capture;
        logic div_step;
        logic rem_step;
        logic mul;
        logic addr;
        logic wr_first;
        logic wr_second;
        logic rd;
        logic out_load;
    } t_rfs_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              out_free;
    } t_rfs_status;

endpackage
`default_nettype wire

// File: design/rfs_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_in_if
// Request channel: load or read words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rfs_in_if import rfs_pkg::*;;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [IDX_W-1:0]  byte_index;
    logic [DATA_W-1:0] source_byte;

    modport source (output valid, output kind, output byte_index, output source_byte,
                    input ready);
    modport sink   (input valid, input kind, input byte_index, input source_byte,
                    output ready);
endinterface
`default_nettype wire

// File: design/rfs_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_out_if
// Result channel: one word per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rfs_out_if import rfs_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              was_read;

    modport source (output valid, output read_data, output was_read, input ready);
    modport sink   (input valid, input read_data, input was_read, output ready);
endinterface
`default_nettype wire

// File: design/rfs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_ctrl
// Sequencer that walks one word at a time through divide, multiply, address,
// write, read and result steps of the datapath.
// ----------------------------------------------------------------------------
module rfs_ctrl import rfs_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_kind,
    output logic             o_in_ready,
    input  wire t_rfs_status i_status,
    output t_rfs_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ADDR = 3'd3;
    localparam logic [2:0] S_WR1  = 3'd4;
    localparam logic [2:0] S_WR2  = 3'd5;
    localparam logic [2:0] S_RD   = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    localparam int               DIV_CYCLES = 2;
    localparam int               CNT_W      = $clog2(DIV_CYCLES);
    localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(DIV_CYCLES - 1);

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             whole_byte;

    assign whole_byte = (i_status.mode inside {ROT_0, ROT_180});

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_cnt      = '0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_in_kind == KIND_READ) begin
                        n_state = S_RD;
                    end else if (whole_byte) begin
                        n_state = S_ADDR;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // The first cycle forms the quotient, the second the remainder.
                o_cmd.div_step = (r_cnt == '0);
                o_cmd.rem_step = (r_cnt != '0);
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = S_WR1;
            end
            S_WR1: begin
                o_cmd.wr_first = 1'b1;
                n_state        = whole_byte ? S_FIN : S_WR2;
            end
            S_WR2: begin
                o_cmd.wr_second = 1'b1;
                n_state         = S_FIN;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_FIN;
            end
            S_FIN: begin
                // Hold the finished word until the output register has room.
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// File: design/rfs_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_datapath
// Rotation register, constant divider, target address generation, the
// nibble-enabled frame memory and the output register.
// ----------------------------------------------------------------------------
module rfs_datapath import rfs_pkg::*; #(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_rfs_cmd          i_cmd,
    output t_rfs_status            o_status,
    input  wire logic              i_cfg_we,
    input  wire logic [MODE_W-1:0] i_cfg_data,
    input  wire logic              i_kind,
    input  wire logic [IDX_W-1:0]  i_byte_index,
    input  wire logic [DATA_W-1:0] i_source_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [DATA_W-1:0]      o_read_data,
    output logic                   o_was_read
);

    localparam int RB     = PANEL_WIDTH / 2;
    localparam int SB     = PANEL_HEIGHT / 2;
    localparam int TOTAL  = PANEL_WIDTH * PANEL_HEIGHT / 2;
    localparam int LIM    = 2 * RB * SB;
    localparam int CW0    = $clog2(PANEL_WIDTH * PANEL_HEIGHT + 1);
    localparam int CW     = ((CW0 > IDX_W) ? CW0 : IDX_W) + 2;
    localparam int REM_W  = $clog2(SB + 1);
    localparam int DIV_SH = IDX_W + $clog2(SB);
    localparam int DIV_M  = ((1 << DIV_SH) + SB - 1) / SB;
    localparam int DIV_PW = 2 * IDX_W + 2;

    logic [MODE_W-1:0] r_mode;
    logic              r_kind;
    logic [IDX_W-1:0]  r_idx;
    logic [DATA_W-1:0] r_byte;
    logic [IDX_W-1:0]  r_quo;
    logic [REM_W-1:0]  r_rem;
    logic [CW-1:0]     r_prod;
    logic [IDX_W-1:0]  r_t1, r_t2;
    logic              r_ok1, r_ok2, r_hi;
    logic [DATA_W-1:0] r_rdata;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_data;
    logic              r_was_read;

    logic [DATA_W-1:0] mem [STORE_DEPTH];

    // Divide by the constant source row length: a rounded-up reciprocal
    // multiply gives the exact quotient for every 13-bit index, and the
    // remainder follows by multiplying back and subtracting.
    logic [DIV_PW-1:0] div_prod;
    logic [IDX_W-1:0]  quo_back;

    assign div_prod = DIV_PW'(r_idx) * DIV_PW'(DIV_M);
    assign quo_back = IDX_W'(r_quo * IDX_W'(SB));

    logic [CW-1:0] i_ext, mul_factor, mul_prod;
    logic [CW-1:0] idx_ext, j_ext, a1, a2;
    logic          in_img;

    assign i_ext      = CW'(r_rem);
    assign mul_factor = (r_mode == ROT_90) ? ((i_ext << 1) + CW'(1))
                                           : (CW'(PANEL_HEIGHT - 1) - (i_ext << 1));
    assign mul_prod   = CW'(mul_factor * CW'(RB));

    assign idx_ext = CW'(r_idx);
    assign j_ext   = CW'(r_quo[IDX_W-1:1]);

    always_comb begin
        a1     = idx_ext;
        a2     = idx_ext;
        in_img = (idx_ext < CW'(TOTAL));
        case (r_mode)
            ROT_0: begin
                a1 = idx_ext;
            end
            ROT_180: begin
                a1 = CW'(TOTAL - 1) - idx_ext;
            end
            ROT_90: begin
                a1     = r_prod - j_ext - CW'(1);
                a2     = r_prod + CW'(RB - 1) - j_ext;
                in_img = (idx_ext < CW'(LIM));
            end
            ROT_270: begin
                a1     = r_prod + j_ext;
                a2     = r_prod + j_ext - CW'(RB);
                in_img = (idx_ext < CW'(LIM));
            end
            default: begin
                a1 = idx_ext;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ROT_0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_idx  <= i_byte_index;
            r_byte <= i_source_byte;
        end else if (i_cmd.div_step) begin
            r_quo <= IDX_W'(div_prod >> DIV_SH);
        end else if (i_cmd.rem_step) begin
            r_rem <= REM_W'(r_idx - quo_back);
        end
        if (i_cmd.mul) begin
            r_prod <= mul_prod;
        end
        if (i_cmd.addr) begin
            r_t1  <= a1[IDX_W-1:0];
            r_t2  <= a2[IDX_W-1:0];
            r_ok1 <= in_img && (a1 < CW'(STORE_DEPTH));
            r_ok2 <= in_img && (a2 < CW'(STORE_DEPTH));
            // Ninety puts odd source rows in the high nibble, two-seventy the even ones.
            r_hi  <= (r_mode == ROT_90) ? r_quo[0] : !r_quo[0];
        end
    end

    // Single write port with nibble enables.
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [1:0]        wr_mask;
    logic [DATA_W-1:0] wr_data;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_t1;
        wr_mask = 2'b11;
        wr_data = r_byte;
        if (i_cmd.wr_first) begin
            wr_en = r_ok1;
            case (r_mode)
                ROT_0: begin
                    wr_data = r_byte;
                end
                ROT_180: begin
                    wr_data = {r_byte[3:0], r_byte[7:4]};
                end
                default: begin
                    wr_data = {r_byte[7:4], r_byte[7:4]};
                    wr_mask = r_hi ? 2'b10 : 2'b01;
                end
            endcase
        end else if (i_cmd.wr_second) begin
            wr_en   = r_ok2;
            wr_addr = r_t2;
            wr_data = {r_byte[3:0], r_byte[3:0]};
            wr_mask = r_hi ? 2'b10 : 2'b01;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (wr_mask[1]) begin
                mem[wr_addr][7:4] <= wr_data[7:4];
            end
            if (wr_mask[0]) begin
                mem[wr_addr][3:0] <= wr_data[3:0];
            end
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_was_read  <= (r_kind == KIND_READ);
            r_read_data <= (r_kind == KIND_READ) ? r_rdata : '0;
        end
    end

    assign o_status.mode     = r_mode;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_read_data       = r_read_data;
    assign o_was_read        = r_was_read;

endmodule
`default_nettype wire

// File: design/rotating_4bpp_frame_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotating_4bpp_frame_store
// Frame store for a packed 4bpp panel that places loaded bitmap bytes at
// their rotated positions and answers byte reads.
// ----------------------------------------------------------------------------
// The block handles one word at a time and returns exactly one result word
// per request; a new request is taken as soon as the previous one has reached
// the output register, even while that result still waits to be taken. A read
// goes through address capture, a registered memory read and the result load.
// A load at 0 or 180 degrees goes through capture, address, a write and the
// result load. A load at 90 or 270 degrees goes through capture, two divider
// steps that split the byte index by the source row length (PANEL_HEIGHT/2)
// with a reciprocal multiply and a remainder, one multiply, one address step,
// two nibble writes through the single write port of the memory and the result
// load, which waits until the output register has room. The 8192-byte store is
// not cleared by reset; a byte that was never written reads back as undefined data.
// ----------------------------------------------------------------------------
module rotating_4bpp_frame_store import rfs_pkg::*; #(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    rfs_in_if.sink                 i_in,
    rfs_out_if.source              o_out,
    input  wire logic              i_cfg_we,
    input  wire logic [MODE_W-1:0] i_cfg_data
);

    t_rfs_cmd    cmd;
    t_rfs_status status;

    rfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rfs_datapath #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_in.kind),
        .i_byte_index  (i_in.byte_index),
        .i_source_byte (i_in.source_byte),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_read_data   (o_out.read_data),
        .o_was_read    (o_out.was_read)
    );

endmodule
`default_nettype wire

// File: design/rfs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_checker
// Port-level checks for the rotating frame store, bound to the top level.
// ----------------------------------------------------------------------------
module rfs_checker import rfs_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [DATA_W-1:0] i_read_data,
    input wire logic              i_was_read
);

    // Nothing is offered at the output right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid after reset");

    // Requests are worked on one at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while another is in flight");

    // A load answers with zero data.
    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_was_read) |-> (i_read_data == '0))
        else $error("load result carries nonzero data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_read_data) && $stable(i_was_read)))
        else $error("stalled result word changed");

endmodule

bind rotating_4bpp_frame_store rfs_checker u_rfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_read_data (o_out.read_data),
    .i_was_read  (o_out.was_read)
);
`default_nettype wire

// File: test/rotating_4bpp_frame_store_tb.sv
// ----------------------------------------------------------------------------
// rotating_4bpp_frame_store_tb
// Self-checking bench for the rotating 4bpp frame store. Load and read words
// go in through the request channel while a scoreboard keeps its own image of
// the rotated frame and predicts every result word in order. Directed loads
// cover the corners of the image under each rotation. Random traffic follows
// them under three flow-control patterns and all four rotations.
// ----------------------------------------------------------------------------
module rotating_4bpp_frame_store_tb;
    import rfs_pkg::*;

    localparam int ROW_BYTES     = PANEL_WIDTH_DEF / 2;
    localparam int SRC_ROW_BYTES = PANEL_HEIGHT_DEF / 2;
    localparam int IMAGE_BYTES   = PANEL_WIDTH_DEF * PANEL_HEIGHT_DEF / 2;
    localparam int WORDS_PER_LEG = 150;
    localparam int TAIL_CYCLES   = 30;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] pixels;
    } t_request;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              was_read;
    } t_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_we;
    logic [MODE_W-1:0] cfg_data;

    rfs_in_if  req_ch ();
    rfs_out_if res_ch ();

    rotating_4bpp_frame_store dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_ch.sink),
        .o_out      (res_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // Scoreboard image of the frame. Bit 1 of nib_valid marks the high nibble
    // as written, bit 0 the low nibble; only fully written bytes are read.
    logic [DATA_W-1:0] frame_img [STORE_DEPTH];
    logic [1:0]        nib_valid [STORE_DEPTH];
    int                filled_addrs[$];
    int                fresh_addrs[$];
    logic [MODE_W-1:0] rot_mode;
    t_result           pending_results[$];

    int send_idle_pct;
    int recv_idle_pct;
    int words_sent;
    int reads_sent;
    int mismatches;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic void mark_written(int addr, logic [1:0] nibs);
        if (nib_valid[addr] != 2'b11 && (nib_valid[addr] | nibs) == 2'b11)
            filled_addrs.push_back(addr);
        nib_valid[addr] |= nibs;
        fresh_addrs.push_back(addr);
    endfunction

    function automatic void put_byte(int addr, logic [DATA_W-1:0] val);
        if (addr < 0 || addr >= STORE_DEPTH)
            return;
        frame_img[addr] = val;
        mark_written(addr, 2'b11);
    endfunction

    function automatic void put_pixel(int addr, logic [3:0] pix, bit hi);
        if (addr < 0 || addr >= STORE_DEPTH)
            return;
        if (hi)
            frame_img[addr][7:4] = pix;
        else
            frame_img[addr][3:0] = pix;
        mark_written(addr, hi ? 2'b10 : 2'b01);
    endfunction

    // Applies one request word to the scoreboard image and returns the
    // result word the block must give for it.
    function automatic t_result rotate_and_store(t_request rq);
        t_result    res;
        int         row;
        int         col;
        int         pair;
        int         base;
        bit         odd;
        logic [3:0] hi_pix;
        logic [3:0] lo_pix;

        res.read_data = '0;
        res.was_read  = (rq.kind == KIND_READ);
        hi_pix = rq.pixels[7:4];
        lo_pix = rq.pixels[3:0];
        if (rq.kind == KIND_READ) begin
            res.read_data = frame_img[rq.index];
            return res;
        end
        case (rot_mode)
            ROT_0: begin
                if (rq.index < IMAGE_BYTES)
                    put_byte(int'(rq.index), rq.pixels);
            end
            ROT_180: begin
                if (rq.index < IMAGE_BYTES)
                    put_byte(IMAGE_BYTES - 1 - int'(rq.index), {lo_pix, hi_pix});
            end
            default: begin
                // Quarter turns: the source is PANEL_HEIGHT pixels wide, so
                // each source row pair fills one byte column of the frame.
                if (rq.index < 2 * ROW_BYTES * SRC_ROW_BYTES) begin
                    row  = int'(rq.index) / SRC_ROW_BYTES;
                    col  = int'(rq.index) % SRC_ROW_BYTES;
                    pair = row / 2;
                    odd  = (row % 2) == 1;
                    if (rot_mode == ROT_90) begin
                        put_pixel((2 * col + 1) * ROW_BYTES - pair - 1, hi_pix, odd);
                        put_pixel((2 * col + 2) * ROW_BYTES - pair - 1, lo_pix, odd);
                    end else begin
                        base = (PANEL_HEIGHT_DEF - 1 - 2 * col) * ROW_BYTES + pair;
                        put_pixel(base, hi_pix, !odd);
                        put_pixel(base - ROW_BYTES, lo_pix, !odd);
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic send_word(logic kind, logic [IDX_W-1:0] index,
                             logic [DATA_W-1:0] pixels);
        t_request rq;
        rq = '{kind, index, pixels};
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= kind;
        req_ch.byte_index  <= index;
        req_ch.source_byte <= pixels;
        do
            @(posedge i_clk);
        while (!(req_ch.valid && req_ch.ready));
        pending_results.push_back(rotate_and_store(rq));
        words_sent++;
        if (kind == KIND_READ)
            reads_sent++;
    endtask

    // Reads back every byte touched by the latest loads that is now whole.
    task automatic read_back_fresh();
        int addrs[$];
        addrs = fresh_addrs;
        fresh_addrs = {};
        foreach (addrs[k])
            if (nib_valid[addrs[k]] == 2'b11)
                send_word(KIND_READ, IDX_W'(addrs[k]), DATA_W'($urandom_range(0, 255)));
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_rotation(logic [MODE_W-1:0] mode);
        wait_for_results();
        cfg_we   <= 1'b1;
        cfg_data <= mode;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        rot_mode = mode;
    endtask

    task automatic test_unrotated();
        set_rotation(ROT_0);
        fresh_addrs = {};
        send_word(KIND_LOAD, 13'd0, 8'hFF);
        send_word(KIND_LOAD, IDX_W'(IMAGE_BYTES - 1), 8'h00);
        send_word(KIND_LOAD, 13'h0AAA, 8'h5A);
        send_word(KIND_LOAD, 13'h1555, 8'hA5);
        read_back_fresh();
    endtask

    task automatic test_half_turn();
        set_rotation(ROT_180);
        fresh_addrs = {};
        send_word(KIND_LOAD, 13'd0, 8'h1E);
        send_word(KIND_LOAD, IDX_W'(IMAGE_BYTES - 1), 8'hF0);
        read_back_fresh();
    endtask

    // A source row pair fills both nibbles of the same two frame bytes.
    task automatic test_quarter_turns();
        set_rotation(ROT_90);
        fresh_addrs = {};
        send_word(KIND_LOAD, 13'd0, 8'hC3);
        send_word(KIND_LOAD, IDX_W'(SRC_ROW_BYTES), 8'h5A);
        read_back_fresh();
        set_rotation(ROT_270);
        send_word(KIND_LOAD, IDX_W'(IMAGE_BYTES - 1 - SRC_ROW_BYTES), 8'h96);
        send_word(KIND_LOAD, IDX_W'(IMAGE_BYTES - 1), 8'h0F);
        read_back_fresh();
    endtask

    task automatic random_step();
        int pick;
        int row;
        int col;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            fresh_addrs = {};
            if (rot_mode == ROT_90 || rot_mode == ROT_270) begin
                row = 2 * $urandom_range(0, PANEL_WIDTH_DEF / 2 - 1);
                col = $urandom_range(0, SRC_ROW_BYTES - 1);
                send_word(KIND_LOAD, IDX_W'(row * SRC_ROW_BYTES + col),
                          DATA_W'($urandom_range(0, 255)));
                send_word(KIND_LOAD, IDX_W'((row + 1) * SRC_ROW_BYTES + col),
                          DATA_W'($urandom_range(0, 255)));
            end else begin
                send_word(KIND_LOAD, IDX_W'($urandom_range(0, STORE_DEPTH - 1)),
                          DATA_W'($urandom_range(0, 255)));
            end
            read_back_fresh();
        end else if (pick < 7 || filled_addrs.size() == 0) begin
            send_word(KIND_LOAD, IDX_W'($urandom_range(0, STORE_DEPTH - 1)),
                      DATA_W'($urandom_range(0, 255)));
        end else begin
            send_word(KIND_READ,
                      IDX_W'(filled_addrs[$urandom_range(0, filled_addrs.size() - 1)]),
                      DATA_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_traffic();
        logic [MODE_W-1:0] order [4];
        int                quota;
        order = '{ROT_0, ROT_90, ROT_180, ROT_270};
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 9;
                    recv_idle_pct = 88;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_idle_pct = 9;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int leg = 0; leg < 4; leg++) begin
                // The sender holds off here until every result is back.
                set_rotation(order[(leg + phase) % 4]);
                quota = words_sent + WORDS_PER_LEG;
                while (words_sent < quota)
                    random_step();
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word, expected none, got read_data %02h was_read %0b",
                         $time, res_ch.read_data, res_ch.was_read);
            end else begin
                want = pending_results.pop_front();
                if (res_ch.read_data !== want.read_data) begin
                    mismatches++;
                    $display("%0t: read_data expected %02h, got %02h",
                             $time, want.read_data, res_ch.read_data);
                end
                if (res_ch.was_read !== want.was_read) begin
                    mismatches++;
                    $display("%0t: was_read expected %0b, got %0b",
                             $time, want.was_read, res_ch.was_read);
                end
            end
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_data           <= ROT_0;
        req_ch.valid       <= 1'b0;
        req_ch.kind        <= KIND_LOAD;
        req_ch.byte_index  <= '0;
        req_ch.source_byte <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        words_sent    = 0;
        reads_sent    = 0;
        mismatches    = 0;
        rot_mode      = ROT_0;
        foreach (nib_valid[a])
            nib_valid[a] = 2'b00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unrotated();
        test_half_turn();
        test_quarter_turns();
        test_random_traffic();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d words (%0d reads, %0d bytes fully written) under all four rotations",
                 words_sent, reads_sent, filled_addrs.size());
        $display("and three flow-control patterns; %0d mismatching fields.", mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: run timed out with %0d results outstanding",
                 $time, pending_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
